[design/bdq_pkg.sv]
// shared types and constants of the bounded deque with search
package bdq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int CMD_W     = 3;
  localparam int VAL_W     = 32;
  localparam int LEN_W     = 5;
  localparam int OUT_W     = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_REM_BACK  = 3'd2,
    CMD_SEARCH    = 3'd3,
    CMD_LENGTH    = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    logic    valid;
    status_t status;
    logic    found;
  } res_t;

endpackage

[design/bounded_deque_with_search.sv]
// inserts, remove, length and unknown commands register their result the cycle after accept
// a search reads entries from the head until a match or the last entry; if empty, it reads none
// throughput: one transaction at a time; a search reads one entry per cycle through the single
// store read port and one comparator, and no new command is taken until the search ends
// reset: head index and entry count clear to zero, output register empties; the entry store
// is not cleared and takes no clearing pass, entries are only read after being written
module bounded_deque_with_search #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic signed [bdq_pkg::VAL_W-1:0] in_tdata,   // [31:0] value
  input  logic [bdq_pkg::CMD_W-1:0]        in_tuser,   // [2:0] cmd
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bdq_pkg::OUT_W-1:0]        out_tdata   // [1:0] status, [2] found, [7:3] length
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // store ports
  logic                      wr_en;
  logic [IW-1:0]             wr_addr;
  logic [bdq_pkg::VAL_W-1:0] wr_data;
  logic                      rd_en;
  logic [IW-1:0]             rd_addr;
  logic [bdq_pkg::VAL_W-1:0] rd_data;

  // result from the sequencer, valid for one cycle
  bdq_pkg::res_t res;
  logic [CW-1:0] res_count;
  logic [CW+bdq_pkg::LEN_W-1:0] count_ext;

  // output register
  logic                      out_valid_r, out_valid_nxt;
  logic [bdq_pkg::OUT_W-1:0] out_data_r, out_data_nxt;
  logic                      out_free;

  bdq_store #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bdq_seq #(
    .DEPTH (DEPTH),
    .IW    (IW),
    .CW    (CW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_cmd    (bdq_pkg::cmd_t'(in_tuser)),
    .in_value  (in_tdata),
    .out_free  (out_free),
    .in_ready  (in_tready),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res       (res),
    .res_count (res_count)
  );

  // a new transaction is taken only when the output register is empty or draining,
  // so the result of that transaction always finds room
  assign out_free = !out_valid_r || out_tready;

  // length field carries the low bits of the count
  assign count_ext = {{bdq_pkg::LEN_W{1'b0}}, res_count};

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res.valid) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {count_ext[bdq_pkg::LEN_W-1:0], res.found, res.status};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> out_free)
    else $error("result produced while output register still held");

  // count never leaves its range
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> res_count <= CW'(DEPTH))
    else $error("entry count above depth");

  // full status only with a full store
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.status == bdq_pkg::ST_FULL) |-> res_count == CW'(DEPTH))
    else $error("full status with room left");

  // empty status only with nothing stored
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.status == bdq_pkg::ST_EMPTY) |-> res_count == '0)
    else $error("empty status with entries stored");

endmodule

[design/bdq_store.sv]
// entry store: one write port and one registered read port
module bdq_store #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF,
  parameter int IW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [IW-1:0]             wr_addr,
  input  logic [bdq_pkg::VAL_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [IW-1:0]             rd_addr,
  output logic [bdq_pkg::VAL_W-1:0] rd_data
);

  logic [bdq_pkg::VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/bdq_seq.sv]
// command sequencer: head and count, pointer updates and the shared compare scan
module bdq_seq #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF,
  parameter int IW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  bdq_pkg::cmd_t                    in_cmd,
  input  logic signed [bdq_pkg::VAL_W-1:0] in_value,
  input  logic                             out_free,
  output logic                             in_ready,
  output logic                             wr_en,
  output logic [IW-1:0]                    wr_addr,
  output logic [bdq_pkg::VAL_W-1:0]        wr_data,
  output logic                             rd_en,
  output logic [IW-1:0]                    rd_addr,
  input  logic [bdq_pkg::VAL_W-1:0]        rd_data,
  output bdq_pkg::res_t                    res,
  output logic [CW-1:0]                    res_count
);

  localparam int SW = CW + 1;

  bdq_pkg::state_t state_r, state_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [bdq_pkg::VAL_W-1:0] key_r, key_nxt;

  logic          accept;
  logic          full;
  logic          empty;
  logic          hit;
  logic [IW-1:0] head_dec;
  logic [IW-1:0] ptr_inc;
  logic [SW-1:0] back_sum;
  logic [IW-1:0] back_pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bdq_pkg::S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    rem_r <= rem_nxt;
    key_r <= key_nxt;
  end

  always_comb begin
    full     = (count_r == CW'(DEPTH));
    empty    = (count_r == '0);
    head_dec = (head_r == '0) ? IW'(DEPTH - 1) : head_r - 1'b1;
    ptr_inc  = (ptr_r == IW'(DEPTH - 1)) ? '0 : ptr_r + 1'b1;
    back_sum = SW'(head_r) + SW'(count_r);
    back_pos = (back_sum >= SW'(DEPTH)) ? IW'(back_sum - SW'(DEPTH)) : IW'(back_sum);
    // the one comparator, reused for every scanned entry
    hit      = (rd_data == key_r);
  end

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    rem_nxt    = rem_r;
    key_nxt    = key_r;
    in_ready   = 1'b0;
    accept     = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = head_r;
    wr_data    = in_value;
    rd_en      = 1'b0;
    rd_addr    = head_r;
    res.valid  = 1'b0;
    res.status = bdq_pkg::ST_OK;
    res.found  = 1'b0;
    unique case (state_r)
      bdq_pkg::S_IDLE: begin
        in_ready = out_free;
        accept   = in_valid && out_free;
        if (accept) begin
          unique case (in_cmd)
            bdq_pkg::CMD_INS_FRONT: begin
              res.valid = 1'b1;
              if (full) begin
                res.status = bdq_pkg::ST_FULL;
              end else begin
                head_nxt  = head_dec;
                wr_en     = 1'b1;
                wr_addr   = head_dec;
                count_nxt = count_r + 1'b1;
              end
            end
            bdq_pkg::CMD_INS_BACK: begin
              res.valid = 1'b1;
              if (full) begin
                res.status = bdq_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = back_pos;
                count_nxt = count_r + 1'b1;
              end
            end
            bdq_pkg::CMD_REM_BACK: begin
              res.valid = 1'b1;
              if (empty) begin
                res.status = bdq_pkg::ST_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
              end
            end
            bdq_pkg::CMD_SEARCH: begin
              if (empty) begin
                res.valid = 1'b1;
              end else begin
                key_nxt   = in_value;
                ptr_nxt   = head_r;
                rem_nxt   = count_r;
                rd_en     = 1'b1;
                rd_addr   = head_r;
                state_nxt = bdq_pkg::S_SCAN;
              end
            end
            default: begin
              res.valid = 1'b1;
            end
          endcase
        end
      end
      bdq_pkg::S_SCAN: begin
        // rd_data holds the entry at ptr_r
        if (hit || rem_r == CW'(1)) begin
          res.valid = 1'b1;
          res.found = hit;
          state_nxt = bdq_pkg::S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_inc;
          ptr_nxt = ptr_inc;
          rem_nxt = rem_r - 1'b1;
        end
      end
      default: begin
        state_nxt = bdq_pkg::S_IDLE;
      end
    endcase
    res_count = count_nxt;
  end

endmodule
